// ===== rtl/core/fpas_pkg.sv =====
// ----------------------------------------------------------------------------
// fpas_pkg
// Shared widths and helpers for the single-precision adder/subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

package fpas_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned EXP_W  = 8;
  localparam int unsigned MAN_W  = 23;
  localparam int unsigned SUM_W  = 27;
  localparam int unsigned LZ_W   = 5;

  // opcode of the command port
  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_t;

  // leading zero count over the 26 low bits of the normalized sum (26 if all zero)
  function automatic logic [LZ_W-1:0] lzc26(input logic [25:0] v);
    logic [LZ_W-1:0] n;
    logic            found;
    n     = LZ_W'(26);
    found = 1'b0;
    for (int i = 25; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = LZ_W'(25 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpas_datapath.sv =====
// ----------------------------------------------------------------------------
// fpas_datapath
// Combinational add/subtract: align, add, normalize, round and pack.
// ----------------------------------------------------------------------------
`default_nettype none

module fpas_datapath
  import fpas_pkg::*;
(
  input  wire logic              sub,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic      [WORD_W-1:0] y
);

  logic             sa, sb, same, pick_b, big_s, sticky0, stck, g, r, l, up;
  logic [EXP_W-1:0] ea, eb, big_e, eyr, low_e;
  logic [8:0]       diff, esi, ey, eyd;
  logic [4:0]       shamt, lz;
  logic [23:0]      ma, mb, big_m, small_m;
  logic [54:0]      aligned;
  logic [SUM_W-1:0] sum, norm;
  logic [25:0]      shifted;
  logic [24:0]      rounded;
  logic [9:0]       eyf;
  logic [22:0]      my;
  logic             sy;

  always_comb begin
    // unpack with hidden bit
    sa = a[31];
    sb = b[31] ^ (sub == CMD_SUB);
    ea = a[30:23];
    eb = b[30:23];
    ma = {(ea != '0), a[22:0]};
    mb = {(eb != '0), b[22:0]};

    // pick the larger operand
    diff   = (ea > eb) ? ({1'b0, ea} - {1'b0, eb}) : ({1'b0, eb} - {1'b0, ea});
    shamt  = (diff > 9'd31) ? 5'd31 : diff[4:0];
    pick_b = (shamt == '0) ? !(ma > mb) : !(ea > eb);
    big_m   = pick_b ? mb : ma;
    small_m = pick_b ? ma : mb;
    big_e   = pick_b ? eb : ea;
    big_s   = pick_b ? sb : sa;

    // align with guard, round and sticky
    aligned = {small_m, 31'b0} >> shamt;
    sticky0 = (aligned[28:0] != '0);
    same    = (sa == sb);
    if (same) sum = {1'b0, big_m, 2'b0} + SUM_W'(aligned[54:29]);
    else      sum = {1'b0, big_m, 2'b0} - SUM_W'(aligned[54:29]);

    // carry renormalize, exponent 255 plus carry keeps the ninth bit
    esi = {1'b0, big_e} + 9'd1;
    if (sum[26]) begin
      if (esi == 9'd255) begin
        eyd  = 9'd255;
        norm = SUM_W'(1) << 25;
        stck = 1'b0;
      end else begin
        eyd  = esi;
        norm = sum >> 1;
        stck = sticky0 | sum[0];
      end
    end else begin
      eyd  = {1'b0, big_e};
      norm = sum;
      stck = sticky0;
    end

    // leading zero normalize, subnormal special shift
    lz    = lzc26(norm[25:0]);
    eyf   = {1'b0, eyd} - {5'b0, lz};
    low_e = {3'b0, eyd[4:0]};
    if (!eyf[9] && eyf != '0) begin
      shifted = norm[25:0] << lz;
      eyr     = eyf[7:0];
    end else begin
      shifted = (low_e == '0) ? norm[25:0] : (norm[25:0] << (eyd[4:0] - 5'd1));
      eyr     = '0;
    end

    // rounding
    g  = shifted[1];
    r  = shifted[0];
    l  = shifted[2];
    up = (g && !r && !stck && l) || (g && !r && same && stck) || (g && r);
    rounded = {1'b0, shifted[25:2]} + {24'b0, up};

    // pack
    if (rounded[24]) begin
      ey = {1'b0, eyr} + 9'd1;
      if (ey > 9'd255) ey = 9'd255;
      my = '0;
    end else if (rounded[23:0] == '0) begin
      ey = '0;
      my = '0;
    end else begin
      ey = {1'b0, eyr};
      my = rounded[22:0];
    end
    sy = (ey == '0 && my == '0) ? (sa & sb) : big_s;
    y  = {sy, ey[7:0], my};
  end

endmodule

`default_nettype wire

// ===== rtl/core/fp32_add_sub_top.sv =====
// ----------------------------------------------------------------------------
// fp32_add_sub_top
// Single-precision add/subtract with registered operands and result.
// ----------------------------------------------------------------------------
// A word is taken whenever start is high; busy is always low, so one word
// can enter every cycle. The result passes the input register, then the
// result register, and appears on out_sum_bits with out_valid high for
// exactly one cycle; the receiver cannot stall, so it must take the word
// in that cycle.
`default_nettype none

module fp32_add_sub_top
  import fpas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_command,
  input  wire logic [WORD_W-1:0] in_operand_a,
  input  wire logic [WORD_W-1:0] in_operand_b,
  output logic                   out_valid,
  output logic      [WORD_W-1:0] out_sum_bits
);

  logic              vld_r, res_vld_r;
  logic              cmd_r;
  logic [WORD_W-1:0] a_r, b_r, res_r, res_nxt;

  assign busy = 1'b0;

  // valid flags of the input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      vld_r     <= start;
      res_vld_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= in_command;
      a_r   <= in_operand_a;
      b_r   <= in_operand_b;
    end
    if (vld_r) res_r <= res_nxt;
  end

  fpas_datapath u_dp (
    .sub (cmd_r),
    .a   (a_r),
    .b   (b_r),
    .y   (res_nxt)
  );

  assign out_valid    = res_vld_r;
  assign out_sum_bits = res_r;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking test of the fp32 add/subtract block: directed corner words,
// then random words, each result checked against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import fpas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic        out_valid;
  logic [31:0] out_sum_bits;

  logic [31:0] sum_q[$];
  int          err_cnt;
  bit          no_idle;

  fp32_add_sub_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_command  (in_command),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_sum_bits(out_sum_bits)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predicted sum of a and (b or -b)
  function automatic logic [31:0] fp_sum(input cmd_t cmd, input logic [31:0] a,
                                         input logic [31:0] b);
    logic        sa, sb, pick_b, same, g, r, l, up;
    logic [7:0]  ea, eb, big_e;
    logic [23:0] ma, mb, big_m, small_m;
    logic [8:0]  diff, esi;
    logic [4:0]  shamt;
    logic [63:0] aligned, sum, norm, shifted, rounded;
    logic        sticky0, stck, big_s;
    logic [8:0]  eyd, ey;
    logic [7:0]  eyr;
    logic [22:0] my;
    int          lz, eyf, low;
    sa = a[31]; ea = a[30:23]; ma = {(ea != 8'd0), a[22:0]};
    sb = b[31] ^ (cmd == CMD_SUB); eb = b[30:23]; mb = {(eb != 8'd0), b[22:0]};
    diff  = (ea > eb) ? {1'b0, ea} - {1'b0, eb} : {1'b0, eb} - {1'b0, ea};
    shamt = (diff > 9'd31) ? 5'd31 : diff[4:0];
    if (shamt == 5'd0) pick_b = !(ma > mb);
    else pick_b = !(ea > eb);
    big_m   = pick_b ? mb : ma;
    small_m = pick_b ? ma : mb;
    big_e   = pick_b ? eb : ea;
    big_s   = pick_b ? sb : sa;
    aligned = ({40'd0, small_m} << 31) >> shamt;
    sticky0 = (aligned[28:0] != 29'd0);
    same    = (sa == sb);
    if (same) sum = ({40'd0, big_m} << 2) + (aligned >> 29);
    else sum = ({40'd0, big_m} << 2) - (aligned >> 29);
    esi = {1'b0, big_e} + 9'd1;
    if (sum[26]) begin
      if (esi == 9'd255) begin
        eyd = 9'd255; norm = 64'd1 << 25; stck = 1'b0;
      end else begin
        eyd = esi; norm = sum >> 1; stck = sticky0 | sum[0];
      end
    end else begin
      eyd = {1'b0, big_e}; norm = sum; stck = sticky0;
    end
    lz = 26;
    for (int i = 25; i >= 0; i--) begin
      if (norm[i] && lz == 26) lz = 25 - i;
    end
    eyf = int'(eyd) - lz;
    if (eyf > 0) begin
      shifted = norm << lz;
      eyr = eyf[7:0];
    end else begin
      // subnormal result uses the low exponent bits as shift
      low = int'(eyd[4:0]);
      shifted = (low == 0) ? norm : norm << (low - 1);
      eyr = 8'd0;
    end
    g = shifted[1]; r = shifted[0]; l = shifted[2];
    up = (g && !r && !stck && l) || (g && !r && same && stck) || (g && r);
    rounded = (shifted >> 2) + 64'(up);
    if (rounded[24]) begin
      ey = {1'b0, eyr} + 9'd1;
      if (ey > 9'd255) ey = 9'd255;
      my = 23'd0;
    end else if (rounded[23:0] == 24'd0) begin
      ey = 9'd0; my = 23'd0;
    end else begin
      ey = {1'b0, eyr}; my = rounded[22:0];
    end
    return {((ey == 9'd0 && my == 23'd0) ? (sa & sb) : big_s), ey[7:0], my};
  endfunction

  // random idle burst on the input side
  task automatic idle_burst();
    int n;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // send one word and record its expected sum
  task automatic send_word(input cmd_t cmd, input logic [31:0] a, input logic [31:0] b);
    idle_burst();
    start        <= 1'b1;
    in_command   <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sum_q.push_back(fp_sum(cmd, a, b));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk);
  endtask

  // random float with biased exponent
  function automatic logic [31:0] rand_fp();
    logic [7:0] e;
    case ($urandom_range(0, 5))
      0: e = 8'd0;
      1: e = 8'd255;
      2: e = 8'($urandom_range(250, 255));
      3: e = 8'($urandom_range(0, 4));
      default: e = 8'($urandom_range(0, 255));
    endcase
    return {1'($urandom), e, 23'($urandom)};
  endfunction

  task automatic test_directed();
    logic [31:0] v[10];
    v = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
          32'h0000_0001, 32'h007F_FFFF, 32'h3F80_0000, 32'h0080_0000, 32'h3F80_0001};
    // zero results, sign rule, saturation, subnormals, rounding
    send_word(CMD_ADD, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_SUB, 32'h8000_0000, 32'h0000_0000);
    send_word(CMD_SUB, 32'h3F80_0000, 32'h3F80_0000);
    send_word(CMD_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_word(CMD_ADD, 32'h7F00_0000, 32'h7F00_0000);
    send_word(CMD_ADD, 32'h7F80_0000, 32'hFF80_0000);
    send_word(CMD_SUB, 32'h0080_0000, 32'h0000_0001);
    send_word(CMD_SUB, 32'h0080_0001, 32'h0080_0000);
    send_word(CMD_ADD, 32'h3F80_0000, 32'h3380_0001);
    send_word(CMD_SUB, 32'h3F80_0000, 32'h3380_0001);
    send_word(CMD_ADD, 32'h3F80_0001, 32'h3400_0000);
    send_word(CMD_ADD, 32'h4F80_0000, 32'h0000_0001);
    for (int i = 0; i < 6; i++)
      send_word(cmd_t'(i[0]), v[i], v[9 - i]);
    send_word(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_SUB, 32'h007F_FFFF, 32'h007F_FFFE);
    // exponent 255 with a carry out
    send_word(CMD_ADD, 32'h7F80_0000, 32'h7F80_0000);
    send_word(CMD_ADD, 32'h7FC0_0000, 32'h7FC0_0000);
  endtask

  task automatic test_random(input int n);
    logic [31:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = rand_fp();
      case ($urandom_range(0, 3))
        0: b = a ^ 32'($urandom_range(0, 7));
        1: b = {1'($urandom), a[30:23] + 8'($urandom_range(0, 3)), 23'($urandom)};
        2: b = $urandom;
        default: b = rand_fp();
      endcase
      send_word(cmd_t'($urandom_range(0, 1)), a, b);
    end
  endtask

  // checker of each result word
  always @(posedge clk) begin
    logic [31:0] exp_sum;
    if (rst_n && out_valid) begin
      if (sum_q.size() == 0) begin
        $error("sum_bits: unexpected word %h", out_sum_bits);
        err_cnt++;
      end else begin
        exp_sum = sum_q.pop_front();
        if (out_sum_bits !== exp_sum) begin
          $error("sum_bits: expected %h actual %h", exp_sum, out_sum_bits);
          err_cnt++;
        end
      end
    end
  end

  // run limit
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    err_cnt      = 0;
    no_idle      = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_command   = 1'b0;
    in_operand_a = '0;
    in_operand_b = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(700);
    wait_drained();
    no_idle = 1'b1;
    test_random(400);
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && sum_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
